[rtl/dsmp_pkg.sv]
// Package for the decimal seconds to milliseconds parser: payload types and constants.
`timescale 1ns / 1ps
package dsmp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [30:0] millis;
    logic        bad_input;
  } out_t;

  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [7:0]  CHAR_DOT   = 8'h2e;

  localparam int unsigned FRAC_DIGITS = 3;
  localparam logic [3:0]  ROUND_DIGIT = 4'd5;

  // Largest whole seconds value (22 bits), kept here already scaled to ms.
  localparam logic [31:0] SEC_MS_MAX = 32'd4194303000;
  localparam logic [30:0] MS_MAX     = 31'h7fff_ffff;

endpackage

[rtl/decimal_seconds_to_ms_parser_top.sv]
// Top level of the decimal seconds to milliseconds parser.
`timescale 1ns / 1ps
//
// Usage:
//   The input channel (in_valid / in_ready / in_data) carries one ASCII
//   character per transfer; in_data.last_char marks the end of a string.
//   Digits before a single '.' are whole seconds, up to three fraction
//   digits are kept, a fourth digit of 5 or more rounds up, later digits
//   are dropped. Any other byte or a second '.' flags bad_input.
//   The result channel (out_valid / out_ready / out_data) gives one transfer
//   per string: millis saturated at 2147483647, or 0 with bad_input set.
// Timing:
//   One character per cycle sustained, except that a final character waits
//   while the result register is occupied. A character is captured in the
//   input register and folded into the running state; the last one loads
//   the result register, which offers the result on the output channel.
//   The running seconds value is kept pre-scaled to milliseconds, so the
//   longest path is one constant multiply-add plus the fraction add and the
//   saturation compare.
// Reset: rst_n (synchronous, active low) empties both registers and clears
//   the parse state. When the receiver stalls, non-final characters keep
//   flowing; a final character waits in the input register until the
//   result register frees, and in_ready is low only while it waits.
module decimal_seconds_to_ms_parser_top
  import dsmp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Input register stage.
  logic s1_valid_r, s1_valid_nxt;
  in_t  s1_data_r;
  logic s1_adv;

  // Parse state.
  logic [31:0] whole_ms_r, whole_ms_nxt;   // whole seconds times 1000
  logic        sec_ovf_r, sec_ovf_nxt;
  logic        in_frac_r, in_frac_nxt;
  logic [2:0]  frac_cnt_r, frac_cnt_nxt;
  logic [9:0]  frac_val_r, frac_val_nxt;
  logic        err_r, err_nxt;

  // Result register.
  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;

  logic        is_digit;
  logic [3:0]  digit;
  logic [35:0] ms_cand;
  logic [13:0] frac_cand;
  logic [16:0] frac_pad;
  logic [32:0] ms_sum;
  logic        load_out;

  // Hold a final character while the result register is still occupied.
  assign s1_adv   = s1_valid_r && (!s1_data_r.last_char || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign load_out = s1_adv && s1_data_r.last_char;

  always_comb begin
    s1_valid_nxt = in_valid ? 1'b1 : (s1_valid_r && !s1_adv);
  end

  // Fold one character into the state.
  always_comb begin
    is_digit  = s1_data_r.char_code inside {[CHAR_ZERO:CHAR_NINE]};
    digit     = s1_data_r.char_code[3:0];
    ms_cand   = {4'd0, whole_ms_r} * 36'd10 + 36'(digit) * 36'd1000;
    frac_cand = 14'(frac_val_r) * 14'd10 + 14'(digit);

    whole_ms_nxt = whole_ms_r;
    sec_ovf_nxt  = sec_ovf_r;
    in_frac_nxt  = in_frac_r;
    frac_cnt_nxt = frac_cnt_r;
    frac_val_nxt = frac_val_r;
    err_nxt      = err_r;

    if (is_digit) begin
      if (!in_frac_r) begin
        if (!sec_ovf_r) begin
          if (ms_cand <= 36'(SEC_MS_MAX)) begin
            whole_ms_nxt = ms_cand[31:0];
          end else begin
            sec_ovf_nxt = 1'b1;
          end
        end
      end else if (frac_cnt_r < 3'(FRAC_DIGITS)) begin
        frac_val_nxt = frac_cand[9:0];
        frac_cnt_nxt = frac_cnt_r + 3'd1;
      end else if (frac_cnt_r == 3'(FRAC_DIGITS)) begin
        if (digit >= ROUND_DIGIT) begin
          frac_val_nxt = frac_val_r + 10'd1;
        end
        frac_cnt_nxt = 3'(FRAC_DIGITS + 1);
      end
    end else if (s1_data_r.char_code == CHAR_DOT && !in_frac_r) begin
      in_frac_nxt = 1'b1;
    end else begin
      err_nxt = 1'b1;
    end
  end

  // Pad a short fraction and build the result from the updated state.
  always_comb begin
    case (frac_cnt_nxt)
      3'd1:    frac_pad = 17'(frac_val_nxt) * 17'd100;
      3'd2:    frac_pad = 17'(frac_val_nxt) * 17'd10;
      default: frac_pad = 17'(frac_val_nxt);
    endcase
    ms_sum = {1'b0, whole_ms_nxt} + 33'(frac_pad[9:0]);

    if (err_nxt) begin
      out_nxt.millis    = '0;
      out_nxt.bad_input = 1'b1;
    end else if (sec_ovf_nxt || ms_sum > 33'(MS_MAX)) begin
      out_nxt.millis    = MS_MAX;
      out_nxt.bad_input = 1'b0;
    end else begin
      out_nxt.millis    = ms_sum[30:0];
      out_nxt.bad_input = 1'b0;
    end

    out_valid_nxt = load_out || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      whole_ms_r  <= '0;
      sec_ovf_r   <= 1'b0;
      in_frac_r   <= 1'b0;
      frac_cnt_r  <= '0;
      frac_val_r  <= '0;
      err_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_out) begin
        // End of string: clear the parse state for the next one.
        whole_ms_r <= '0;
        sec_ovf_r  <= 1'b0;
        in_frac_r  <= 1'b0;
        frac_cnt_r <= '0;
        frac_val_r <= '0;
        err_r      <= 1'b0;
      end else if (s1_adv) begin
        whole_ms_r <= whole_ms_nxt;
        sec_ovf_r  <= sec_ovf_nxt;
        in_frac_r  <= in_frac_nxt;
        frac_cnt_r <= frac_cnt_nxt;
        frac_val_r <= frac_val_nxt;
        err_r      <= err_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.bad_input |-> out_r.millis == '0)
    else $error("bad_input result carries nonzero millis");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    frac_cnt_r <= 3'(FRAC_DIGITS + 1) && frac_val_r <= 10'd1000)
    else $error("fraction state out of range");

  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    whole_ms_r <= SEC_MS_MAX)
    else $error("seconds accumulator beyond 22-bit range");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && !in_frac_r && !err_r && frac_cnt_r == '0
                 && whole_ms_r == '0 && !sec_ovf_r)
    else $error("string end did not post result and clear state");

endmodule
